### rtl/mstg_pkg.sv
// Shared types, codes and constants of the multichannel tone synthesizer.
// Used by the waveform shaper and the top level.
`timescale 1ns / 1ps

package mstg_pkg;

	localparam int VOICE_COUNT_DEF = 4;
	localparam int SINE_DEPTH_DEF  = 256;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// Register reset values.
	localparam logic [15:0] NOTE_LENGTH_RST     = 16'd24000;
	localparam logic [23:0] FADE_RECIPROCAL_RST = 24'd699;
	localparam logic [23:0] SINE_STEP_RST       = 24'd153791;
	localparam logic [23:0] SQUARE_STEP_RST     = 24'd182799;
	localparam logic [23:0] TRIANGLE_STEP_RST   = 24'd230337;
	localparam logic [14:0] VOICE_GAIN_RST      = 15'd4915;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	// Quarter-wave sine polynomial in Q30.
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] SIN_C1  = 31'd1686629713;
	localparam logic [30:0] SIN_C3  = 31'd693598672;
	localparam logic [30:0] SIN_C5  = 31'd85569306;
	localparam logic [30:0] SIN_C7  = 31'd5026990;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_PLAY = 2'd1,
		OP_STOP = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_NOTE_LENGTH     = 3'd0,
		REG_FADE_RECIPROCAL = 3'd1,
		REG_SINE_STEP       = 3'd2,
		REG_SQUARE_STEP     = 3'd3,
		REG_TRIANGLE_STEP   = 3'd4,
		REG_VOICE_GAIN      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_NOISE    = 2'd3
	} wave_t;

	typedef struct packed {
		wave_t       wave;
		logic [23:0] phase;
		logic [15:0] remaining;
	} voice_entry_t;

	// Waveform value of one voice as sign and magnitude.
	typedef struct packed {
		logic        is_sine;
		logic        is_noise;
		logic        neg;
		logic [15:0] mag;
		logic [30:0] sine_u;
	} wave_info_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WAVE,
		ST_SIN_SQ,
		ST_SIN_MUL,
		ST_SIN_SUB,
		ST_SIN_FIN,
		ST_SIN_RND,
		ST_ENV,
		ST_ENV2,
		ST_SCALE,
		ST_ACC,
		ST_NEXT,
		ST_EMIT
	} state_t;

endpackage

### rtl/mstg_in_if.sv
// Input channel of the tone synthesizer: tick, play and stop words.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface mstg_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [2:0]        voice;
	logic [7:0]        sfx_id;
	logic signed [15:0] mix_in;

	modport source (output valid, output operation, output voice, output sfx_id,
		output mix_in, input ready);
	modport sink (input valid, input operation, input voice, input sfx_id,
		input mix_in, output ready);
endinterface

### rtl/mstg_out_if.sv
// Output channel of the tone synthesizer: one mixed sample word per tick.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface mstg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [7:0]         active_voices;

	modport source (output valid, output mixed_sample, output active_voices,
		input ready);
	modport sink (input valid, input mixed_sample, input active_voices,
		output ready);
endinterface

### rtl/mstg_wave.sv
// Waveform shaper: square, triangle and noise values, and the folded sine argument.
// Depends on mstg_pkg for the voice entry and waveform info types and constants.
`timescale 1ns / 1ps

module mstg_wave #(
	parameter int SINE_TABLE_DEPTH = mstg_pkg::SINE_DEPTH_DEF
) (
	input  mstg_pkg::voice_entry_t entry,
	input  logic [15:0]            lfsr,
	output mstg_pkg::wave_info_t   info,
	output logic [15:0]            lfsr_next
);

	localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);

	logic [SINE_BITS-1:0] k;
	logic [1:0]           quad;
	logic [29:0]          frac;
	logic [17:0]          tx;
	logic [17:0]          d_hi;
	logic [17:0]          d_lo;
	logic [17:0]          d_top;

	assign k     = entry.phase[23 -: SINE_BITS];
	assign quad  = k[SINE_BITS-1 -: 2];
	assign frac  = {k[SINE_BITS-3:0], {(32 - SINE_BITS){1'b0}}};
	assign tx    = {1'b0, entry.phase[23:7]};
	assign d_hi  = 18'd65536 - tx;
	assign d_lo  = tx - 18'd65536;
	assign d_top = 18'd131072 - tx;

	assign lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? mstg_pkg::LFSR_TAPS : 16'h0000);

	always_comb begin
		info          = '0;
		info.sine_u   = quad[0] ? (mstg_pkg::Q30_ONE - {1'b0, frac}) : {1'b0, frac};
		case (entry.wave)
			mstg_pkg::WAVE_SINE: begin
				info.is_sine = 1'b1;
				info.neg     = quad[1];
			end
			mstg_pkg::WAVE_SQUARE: begin
				info.neg = entry.phase[23];
				info.mag = entry.phase[23] ? 16'd32768 : 16'd32767;
			end
			mstg_pkg::WAVE_TRIANGLE: begin
				if (tx < 18'd32768) begin
					info.mag = tx[15:0];
				end else if (tx == 18'd32768) begin
					info.mag = 16'd32767;
				end else if (tx <= 18'd65536) begin
					info.mag = d_hi[15:0];
				end else if (tx < 18'd98304) begin
					info.neg = 1'b1;
					info.mag = d_lo[15:0];
				end else begin
					info.neg = 1'b1;
					info.mag = d_top[15:0];
				end
			end
			default: begin
				// Noise value is the stepped register minus half scale.
				info.is_noise = 1'b1;
				info.neg      = ~lfsr_next[15];
				info.mag      = lfsr_next[15] ? {1'b0, lfsr_next[14:0]}
					: (16'h8000 - lfsr_next);
			end
		endcase
	end

endmodule

### rtl/multichannel_sfx_tone_synth.sv
// Multichannel tone synthesizer top level: voice memory, sequencer and shared multiplier.
// Depends on mstg_pkg, mstg_in_if, mstg_out_if and mstg_wave.
`timescale 1ns / 1ps

// A play or stop word, and an unused operation code, is taken while idle and
// gives no output word. A tick word walks the voices one after another through
// the voice memory and a single shared 31 by 31 bit multiplier: an idle voice
// passes the read, wave and next states only, an active square, triangle or noise
// voice also the envelope, scale and accumulate states, and an active sine voice
// the polynomial states as well, since the sine polynomial needs five products.
// After the last voice a tick leaves one output word in the output register; the
// next word is taken while that one waits. The voice memory needs no clearing
// pass: a voice entry is used only while its active flag, held in flip-flops, is
// set, and a play word writes the whole entry.
module multichannel_sfx_tone_synth #(
	parameter int VOICE_COUNT      = mstg_pkg::VOICE_COUNT_DEF,
	parameter int SINE_TABLE_DEPTH = mstg_pkg::SINE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mstg_in_if.sink                          in_ch,
	mstg_out_if.source                       out_ch,
	input  logic                             cfg_write,
	input  logic [mstg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mstg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int ACC_W  = 17 + $clog2(VOICE_COUNT + 1);

	// Configuration registers.
	logic [15:0] note_length_q;
	logic [23:0] fade_q;
	logic [23:0] sine_step_q;
	logic [23:0] square_step_q;
	logic [23:0] triangle_step_q;
	logic [14:0] gain_q;

	mstg_pkg::state_t state_q, state_d;

	logic [VIDX_W-1:0]      vidx_q;
	logic [VOICE_COUNT-1:0] active_q;
	logic [15:0]            lfsr_q;

	mstg_pkg::voice_entry_t mem [VOICE_COUNT];
	mstg_pkg::voice_entry_t rd_q;
	mstg_pkg::voice_entry_t mem_wdata;
	logic [VIDX_W-1:0]      mem_waddr;
	logic                   mem_we;
	logic                   rd_en;

	logic [61:0] prod_q;
	logic [30:0] mul_a;
	logic [30:0] mul_b;
	logic        mul_en;

	logic [30:0] u_q;
	logic [30:0] u2_q;
	logic [30:0] p_q;
	logic [1:0]  cidx_q;
	logic [15:0] mag_q;
	logic        neg_q;
	logic [15:0] env_q;
	logic signed [ACC_W-1:0] acc_q;

	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic [7:0]         out_active_q;
	logic               out_load;

	mstg_pkg::wave_info_t wave_info;
	logic [15:0]          lfsr_next;

	logic              in_ready;
	logic              in_accept;
	logic              in_voice_ok;
	logic [VIDX_W-1:0] in_vidx;
	logic              last_voice;
	logic              cur_active;

	logic [23:0] step;
	logic [15:0] rem_dec;
	logic [30:0] coef;
	logic [31:0] rnd_sum;
	logic [16:0] rnd_r;
	logic [30:0] env_raw;
	logic [15:0] scaled;
	logic signed [15:0] sat_sample;

	assign in_accept   = in_ch.valid && in_ready;
	assign in_voice_ok = 32'(in_ch.voice) < VOICE_COUNT;
	assign in_vidx     = in_ch.voice[VIDX_W-1:0];
	assign last_voice  = vidx_q == VIDX_W'(VOICE_COUNT - 1);
	assign cur_active  = active_q[vidx_q];

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.mixed_sample  = out_sample_q;
	assign out_ch.active_voices = out_active_q;

	mstg_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_wave (
		.entry    (rd_q),
		.lfsr     (lfsr_q),
		.info     (wave_info),
		.lfsr_next(lfsr_next)
	);

	always_comb begin
		case (rd_q.wave)
			mstg_pkg::WAVE_SINE:     step = sine_step_q;
			mstg_pkg::WAVE_SQUARE:   step = square_step_q;
			mstg_pkg::WAVE_TRIANGLE: step = triangle_step_q;
			default:                 step = 24'd0;
		endcase
	end

	always_comb begin
		case (cidx_q)
			2'd0:    coef = mstg_pkg::SIN_C5;
			2'd1:    coef = mstg_pkg::SIN_C3;
			default: coef = mstg_pkg::SIN_C1;
		endcase
	end

	assign rem_dec = (rd_q.remaining == 16'd0) ? 16'd0 : (rd_q.remaining - 16'd1);
	assign rnd_sum = {1'b0, prod_q[60:30]} + 32'd16384;
	assign rnd_r   = rnd_sum[31:15];
	assign env_raw = prod_q[39:9];
	assign scaled  = prod_q[45:30];

	always_comb begin
		if (acc_q > ACC_W'(32767)) begin
			sat_sample = 16'sh7FFF;
		end else if (acc_q < -ACC_W'(32768)) begin
			sat_sample = 16'sh8000;
		end else begin
			sat_sample = acc_q[15:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mstg_pkg::ST_IDLE: begin
				if (in_accept && (in_ch.operation == mstg_pkg::OP_TICK)) begin
					state_d = mstg_pkg::ST_READ;
				end
			end
			mstg_pkg::ST_READ: state_d = mstg_pkg::ST_WAVE;
			mstg_pkg::ST_WAVE: begin
				if (!cur_active) begin
					state_d = mstg_pkg::ST_NEXT;
				end else if (wave_info.is_sine) begin
					state_d = mstg_pkg::ST_SIN_SQ;
				end else begin
					state_d = mstg_pkg::ST_ENV;
				end
			end
			mstg_pkg::ST_SIN_SQ:  state_d = mstg_pkg::ST_SIN_MUL;
			mstg_pkg::ST_SIN_MUL: state_d = mstg_pkg::ST_SIN_SUB;
			mstg_pkg::ST_SIN_SUB: begin
				state_d = (cidx_q == 2'd2) ? mstg_pkg::ST_SIN_FIN : mstg_pkg::ST_SIN_MUL;
			end
			mstg_pkg::ST_SIN_FIN: state_d = mstg_pkg::ST_SIN_RND;
			mstg_pkg::ST_SIN_RND: state_d = mstg_pkg::ST_ENV;
			mstg_pkg::ST_ENV:     state_d = mstg_pkg::ST_ENV2;
			mstg_pkg::ST_ENV2:    state_d = mstg_pkg::ST_SCALE;
			mstg_pkg::ST_SCALE:   state_d = mstg_pkg::ST_ACC;
			mstg_pkg::ST_ACC:     state_d = mstg_pkg::ST_NEXT;
			mstg_pkg::ST_NEXT: begin
				state_d = last_voice ? mstg_pkg::ST_EMIT : mstg_pkg::ST_READ;
			end
			mstg_pkg::ST_EMIT: begin
				if (out_load) begin
					state_d = mstg_pkg::ST_IDLE;
				end
			end
			default: state_d = mstg_pkg::ST_IDLE;
		endcase
	end

	// Control outputs: handshake, memory port and multiplier operands.
	always_comb begin
		in_ready            = 1'b0;
		rd_en               = 1'b0;
		mem_we              = 1'b0;
		mem_waddr           = vidx_q;
		mem_wdata.wave      = rd_q.wave;
		mem_wdata.phase     = rd_q.phase + step;
		mem_wdata.remaining = rem_dec;
		mul_en              = 1'b0;
		mul_a               = '0;
		mul_b               = '0;
		out_load            = 1'b0;
		case (state_q)
			mstg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_accept && (in_ch.operation == mstg_pkg::OP_PLAY) && in_voice_ok) begin
					mem_we              = 1'b1;
					mem_waddr           = in_vidx;
					mem_wdata.wave      = mstg_pkg::wave_t'(in_ch.sfx_id[1:0]);
					mem_wdata.phase     = 24'd0;
					mem_wdata.remaining = note_length_q;
				end
			end
			mstg_pkg::ST_READ: rd_en = 1'b1;
			mstg_pkg::ST_WAVE: begin
				mul_en = cur_active && wave_info.is_sine;
				mul_a  = wave_info.sine_u;
				mul_b  = wave_info.sine_u;
			end
			mstg_pkg::ST_SIN_MUL: begin
				mul_en = 1'b1;
				mul_a  = u2_q;
				mul_b  = p_q;
			end
			mstg_pkg::ST_SIN_FIN: begin
				mul_en = 1'b1;
				mul_a  = u_q;
				mul_b  = p_q;
			end
			mstg_pkg::ST_ENV: begin
				mul_en = 1'b1;
				mul_a  = 31'(rd_q.remaining);
				mul_b  = 31'(fade_q);
			end
			mstg_pkg::ST_ENV2: begin
				mul_en = 1'b1;
				mul_a  = 31'(mag_q);
				mul_b  = 31'(gain_q);
			end
			mstg_pkg::ST_SCALE: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, prod_q[29:0]};
				mul_b  = 31'(env_q);
			end
			mstg_pkg::ST_ACC:  mem_we = 1'b1;
			mstg_pkg::ST_EMIT: out_load = !out_valid_q || out_ch.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[vidx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Datapath registers of the voice walk.
	always_ff @(posedge clk) begin
		case (state_q)
			mstg_pkg::ST_IDLE: begin
				acc_q <= ACC_W'(in_ch.mix_in);
			end
			mstg_pkg::ST_WAVE: begin
				u_q    <= wave_info.sine_u;
				neg_q  <= wave_info.neg;
				mag_q  <= wave_info.mag;
				p_q    <= mstg_pkg::SIN_C7;
				cidx_q <= 2'd0;
			end
			mstg_pkg::ST_SIN_SQ: u2_q <= prod_q[60:30];
			mstg_pkg::ST_SIN_SUB: begin
				p_q    <= coef - prod_q[60:30];
				cidx_q <= cidx_q + 2'd1;
			end
			mstg_pkg::ST_SIN_RND: begin
				mag_q <= (rnd_r > 17'd32767) ? 16'd32767 : rnd_r[15:0];
			end
			mstg_pkg::ST_ENV2: begin
				env_q <= (env_raw > 31'd32768) ? 16'd32768 : env_raw[15:0];
			end
			mstg_pkg::ST_ACC: begin
				acc_q <= neg_q ? (acc_q - ACC_W'(scaled)) : (acc_q + ACC_W'(scaled));
			end
			mstg_pkg::ST_EMIT: begin
				if (out_load) begin
					out_sample_q <= sat_sample;
					out_active_q <= 8'(active_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= mstg_pkg::ST_IDLE;
			vidx_q          <= '0;
			active_q        <= '0;
			lfsr_q          <= mstg_pkg::LFSR_SEED;
			out_valid_q     <= 1'b0;
			note_length_q   <= mstg_pkg::NOTE_LENGTH_RST;
			fade_q          <= mstg_pkg::FADE_RECIPROCAL_RST;
			sine_step_q     <= mstg_pkg::SINE_STEP_RST;
			square_step_q   <= mstg_pkg::SQUARE_STEP_RST;
			triangle_step_q <= mstg_pkg::TRIANGLE_STEP_RST;
			gain_q          <= mstg_pkg::VOICE_GAIN_RST;
		end else begin
			state_q <= state_d;

			if (cfg_write) begin
				case (mstg_pkg::cfg_reg_t'(cfg_index))
					mstg_pkg::REG_NOTE_LENGTH:     note_length_q   <= cfg_data[15:0];
					mstg_pkg::REG_FADE_RECIPROCAL: fade_q          <= cfg_data;
					mstg_pkg::REG_SINE_STEP:       sine_step_q     <= cfg_data;
					mstg_pkg::REG_SQUARE_STEP:     square_step_q   <= cfg_data;
					mstg_pkg::REG_TRIANGLE_STEP:   triangle_step_q <= cfg_data;
					mstg_pkg::REG_VOICE_GAIN:      gain_q          <= cfg_data[14:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				mstg_pkg::ST_IDLE: begin
					if (in_accept) begin
						if (in_ch.operation == mstg_pkg::OP_TICK) begin
							vidx_q <= '0;
						end else if (in_voice_ok) begin
							if (in_ch.operation == mstg_pkg::OP_PLAY) begin
								active_q[in_vidx] <= 1'b1;
							end else if (in_ch.operation == mstg_pkg::OP_STOP) begin
								active_q[in_vidx] <= 1'b0;
							end
						end
					end
				end
				mstg_pkg::ST_WAVE: begin
					// The shared noise register steps once per active noise voice.
					if (cur_active && wave_info.is_noise) begin
						lfsr_q <= lfsr_next;
					end
				end
				mstg_pkg::ST_ACC: active_q[vidx_q] <= rem_dec != 16'd0;
				mstg_pkg::ST_NEXT: begin
					if (!last_voice) begin
						vidx_q <= vidx_q + VIDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
